@@ rtl/core/pesr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesr_pkg
// Shared widths, register indexes, datapath opcodes and channel types of the
// polyline equal-step resampler.
// ----------------------------------------------------------------------------
package pesr_pkg;

  // coordinate and field widths
  localparam int CW        = 16;                      // signed Q11.4 coordinate
  localparam int IW        = 12;                      // step interval, Q8.4
  localparam int MAX_STEPS = 31;                      // step count ceiling
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);   // step count / sample index
  localparam int DW        = CW + 1;                  // coordinate difference
  localparam int SQW       = 2 * DW;                  // squared length
  localparam int REM_W     = DW + 3;                  // root remainder
  localparam int QCW       = DW + IW + STEP_W;        // step quotient compare
  localparam int RW        = DW + 1;                  // doubled magnitude, ratio quotient
  localparam int DEN_W     = STEP_W + 1;              // doubled step count
  localparam int SV_W      = RW + 2;                  // unsaturated sample
  localparam int ITW       = $clog2(RW);              // iteration counter

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CW;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 2'd2;

  localparam logic [IW-1:0] STEP_INTERVAL_RST = 12'd56;

  // datapath opcodes
  localparam int OP_W = 4;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_ACCEPT  = 4'd1;
  localparam op_t OP_DELTA   = 4'd2;
  localparam op_t OP_SQUARE  = 4'd3;
  localparam op_t OP_SUM     = 4'd4;
  localparam op_t OP_SQRT    = 4'd5;
  localparam op_t OP_QSETUP  = 4'd6;
  localparam op_t OP_QSTEP   = 4'd7;
  localparam op_t OP_PRESAVE = 4'd8;
  localparam op_t OP_RSETUP  = 4'd9;
  localparam op_t OP_RSTEP   = 4'd10;
  localparam op_t OP_LOAD    = 4'd11;
  localparam op_t OP_COMMIT  = 4'd12;

  typedef struct packed {
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic                 starts_subpath;
    logic                 closes_subpath;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] sample_x;
    logic signed [CW-1:0] sample_y;
    logic                 last_of_run;
  } sample_t;

  typedef struct packed {
    op_t  op;
    logic seg_close;
  } cmd_t;

  typedef struct packed {
    logic closes;
    logic steps_zero;
    logic more;
  } stat_t;

endpackage

@@ rtl/core/pesr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesr channel interfaces
// Valid/ready channels for vertex requests and sample results.
// ----------------------------------------------------------------------------
interface pesr_vertex_if;
  logic              valid;
  logic              ready;
  pesr_pkg::vertex_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pesr_sample_if;
  logic              valid;
  logic              ready;
  pesr_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/pesr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesr_ctrl
// Sequencer: walks each segment through delta, square, root, step quotient,
// ratio division and sample emission, and drives the result valid.
// ----------------------------------------------------------------------------
module pesr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_starts,
  input  logic            in_closes,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  pesr_pkg::stat_t stat,
  output pesr_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DELTA  = 4'd1;
  localparam logic [3:0] S_SQUARE = 4'd2;
  localparam logic [3:0] S_SUM    = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_QSETUP = 4'd5;
  localparam logic [3:0] S_QDIV   = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_RSETUP = 4'd8;
  localparam logic [3:0] S_RDIV   = 4'd9;
  localparam logic [3:0] S_LOAD   = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  // pre: step count of the closing line, ahead of the line itself
  localparam logic [1:0] PH_PRE   = 2'd0;
  localparam logic [1:0] PH_LINE  = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;

  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [pesr_pkg::ITW-1:0]   it_r, it_nxt;
  logic                       out_valid_r, out_valid_nxt;
  pesr_pkg::op_t              op;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r;
    op            = pesr_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = pesr_pkg::OP_ACCEPT;
          if (!in_starts) begin
            state_nxt = S_DELTA;
            phase_nxt = in_closes ? PH_PRE : PH_LINE;
          end
        end
      end
      S_DELTA: begin
        op        = pesr_pkg::OP_DELTA;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        op        = pesr_pkg::OP_SQUARE;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op        = pesr_pkg::OP_SUM;
        it_nxt    = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        op = pesr_pkg::OP_SQRT;
        if (it_r == pesr_pkg::ITW'(pesr_pkg::DW - 1)) begin
          it_nxt    = '0;
          state_nxt = S_QSETUP;
        end else begin
          it_nxt = it_r + 1'b1;
        end
      end
      S_QSETUP: begin
        op        = pesr_pkg::OP_QSETUP;
        it_nxt    = '0;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        op = pesr_pkg::OP_QSTEP;
        if (it_r == pesr_pkg::ITW'(pesr_pkg::STEP_W - 1)) begin
          it_nxt    = '0;
          state_nxt = S_CHECK;
        end else begin
          it_nxt = it_r + 1'b1;
        end
      end
      S_CHECK: begin
        if (phase_r == PH_PRE) begin
          op        = pesr_pkg::OP_PRESAVE;
          phase_nxt = PH_LINE;
          state_nxt = S_DELTA;
        end else if (stat.steps_zero) begin
          op = pesr_pkg::OP_COMMIT;
          if (phase_r == PH_LINE && stat.closes) begin
            phase_nxt = PH_CLOSE;
            state_nxt = S_DELTA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_RSETUP;
        end
      end
      S_RSETUP: begin
        op        = pesr_pkg::OP_RSETUP;
        it_nxt    = '0;
        state_nxt = S_RDIV;
      end
      S_RDIV: begin
        op = pesr_pkg::OP_RSTEP;
        if (it_r == pesr_pkg::ITW'(pesr_pkg::RW - 1)) begin
          it_nxt    = '0;
          state_nxt = S_LOAD;
        end else begin
          it_nxt = it_r + 1'b1;
        end
      end
      S_LOAD: begin
        op            = pesr_pkg::OP_LOAD;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (stat.more) begin
            op = pesr_pkg::OP_LOAD;
          end else begin
            op            = pesr_pkg::OP_COMMIT;
            out_valid_nxt = 1'b0;
            if (phase_r == PH_LINE && stat.closes) begin
              phase_nxt = PH_CLOSE;
              state_nxt = S_DELTA;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LINE;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign cmd.op        = op;
  assign cmd.seg_close = (phase_r != PH_LINE);

endmodule

@@ rtl/core/pesr_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesr_dpath
// Pen state, configuration registers, x and y squarers, bitwise root, step
// quotient, ratio divider and the incremental interpolator with output stage.
// ----------------------------------------------------------------------------
module pesr_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pesr_pkg::cmd_t                      cmd,
  output pesr_pkg::stat_t                     stat,
  input  pesr_pkg::vertex_t                   in_data,
  input  logic                                cfg_we,
  input  logic [pesr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pesr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pesr_pkg::sample_t                   out_data
);

  localparam int CW    = pesr_pkg::CW;
  localparam int DW    = pesr_pkg::DW;
  localparam int SQW   = pesr_pkg::SQW;
  localparam int REM_W = pesr_pkg::REM_W;
  localparam int QCW   = pesr_pkg::QCW;
  localparam int RW    = pesr_pkg::RW;
  localparam int DEN_W = pesr_pkg::DEN_W;
  localparam int SW    = pesr_pkg::STEP_W;
  localparam int SV_W  = pesr_pkg::SV_W;

  // configuration
  logic [pesr_pkg::IW-1:0] interval_r;
  logic signed [CW-1:0]    center_x_r, center_y_r;

  // pen state
  logic signed [CW-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic signed [CW-1:0] vx_r, vy_r;
  logic                 closes_r, close_nz_r;

  // length and step count
  logic signed [DW-1:0] dx_r, dy_r;
  logic [SQW-1:0]       sqx_r, sqy_r, rad_r;
  logic [REM_W-1:0]     srem_r;
  logic [DW-1:0]        root_r;
  logic                 qact_r;
  logic [DW-1:0]        qrem_r;
  logic [QCW-1:0]       qdv_r;
  logic [SW-1:0]        steps_r, cnt_r;

  // ratio division and interpolation
  logic [DEN_W-1:0]     den_r;
  logic [RW-1:0]        nx_r, ny_r;
  logic [DEN_W-1:0]     rx_r, ry_r;
  logic                 negx_r, negy_r;
  logic [RW-1:0]        accx_r, accy_r;
  logic [DEN_W-1:0]     raccx_r, raccy_r;
  pesr_pkg::sample_t    out_r;

  // segment endpoints
  logic signed [CW-1:0] org_x, org_y, tgt_x, tgt_y;
  assign org_x = cmd.seg_close ? vx_r : prev_x_r;
  assign org_y = cmd.seg_close ? vy_r : prev_y_r;
  assign tgt_x = cmd.seg_close ? start_x_r : vx_r;
  assign tgt_y = cmd.seg_close ? start_y_r : vy_r;

  // squares
  logic signed [SQW-1:0] psx, psy;
  assign psx = dx_r * dx_r;
  assign psy = dy_r * dy_r;

  // root step
  logic [REM_W-1:0] srem_sh, trial;
  logic             sge;
  assign srem_sh = {srem_r[REM_W-3:0], rad_r[SQW-1:SQW-2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign sge     = (srem_sh >= trial);

  // step quotient
  logic [QCW-1:0] lim, lenx, qremx;
  logic           qge;
  assign lim   = QCW'(pesr_pkg::MAX_STEPS) * QCW'(interval_r);
  assign lenx  = QCW'(root_r);
  assign qremx = QCW'(qrem_r);
  assign qge   = (qremx >= qdv_r);

  // ratio division step
  logic [DEN_W:0] tx, ty, denx;
  logic           rgx, rgy;
  assign denx = {1'b0, den_r};
  assign tx   = {rx_r, nx_r[RW-1]};
  assign ty   = {ry_r, ny_r[RW-1]};
  assign rgx  = (tx >= denx);
  assign rgy  = (ty >= denx);

  // interpolation advance
  logic [DEN_W:0] rsx, rsy;
  logic           agx, agy;
  assign rsx = {1'b0, raccx_r} + {1'b0, rx_r};
  assign rsy = {1'b0, raccy_r} + {1'b0, ry_r};
  assign agx = (rsx >= denx);
  assign agy = (rsy >= denx);

  logic [DW-1:0] absx, absy;
  assign absx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign absy = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SV_W-1:0] v);
    logic signed [SV_W-1:0] hi, lo;
    hi = SV_W'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - SV_W'(1);
    if (v > hi)      sat_coord = {1'b0, {(CW-1){1'b1}}};
    else if (v < lo) sat_coord = {1'b1, {(CW-1){1'b0}}};
    else             sat_coord = v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sample_of(
    input logic signed [CW-1:0] org,
    input logic [RW-1:0]        acc,
    input logic                 neg,
    input logic signed [CW-1:0] ctr
  );
    logic signed [SV_W-1:0] off, v;
    off = signed'(SV_W'(acc));
    if (neg) off = -off;
    v = SV_W'(org) + off - SV_W'(ctr);
    sample_of = sat_coord(v);
  endfunction

  logic last_flag;
  assign last_flag = ((DEN_W'(cnt_r) + DEN_W'(1)) == DEN_W'(steps_r))
                     && (cmd.seg_close || !close_nz_r);

  // state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= pesr_pkg::STEP_INTERVAL_RST;
      center_x_r <= '0;
      center_y_r <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      start_x_r  <= '0;
      start_y_r  <= '0;
      closes_r   <= 1'b0;
      close_nz_r <= 1'b0;
      qact_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pesr_pkg::REG_STEP_INTERVAL: interval_r <= cfg_data[pesr_pkg::IW-1:0];
          pesr_pkg::REG_CENTER_X:      center_x_r <= cfg_data;
          pesr_pkg::REG_CENTER_Y:      center_y_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        pesr_pkg::OP_ACCEPT: begin
          closes_r   <= in_data.closes_subpath;
          close_nz_r <= 1'b0;
          if (in_data.starts_subpath) begin
            prev_x_r  <= in_data.vertex_x;
            prev_y_r  <= in_data.vertex_y;
            start_x_r <= in_data.vertex_x;
            start_y_r <= in_data.vertex_y;
          end
        end
        pesr_pkg::OP_QSETUP: begin
          qact_r <= (root_r != '0) && (interval_r != '0) && (lenx < lim);
        end
        pesr_pkg::OP_PRESAVE: close_nz_r <= (steps_r != '0);
        pesr_pkg::OP_COMMIT: begin
          prev_x_r <= tgt_x;
          prev_y_r <= tgt_y;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pesr_pkg::OP_ACCEPT: begin
        vx_r <= in_data.vertex_x;
        vy_r <= in_data.vertex_y;
      end
      pesr_pkg::OP_DELTA: begin
        dx_r <= DW'(tgt_x) - DW'(org_x);
        dy_r <= DW'(tgt_y) - DW'(org_y);
      end
      pesr_pkg::OP_SQUARE: begin
        sqx_r <= unsigned'(psx);
        sqy_r <= unsigned'(psy);
      end
      pesr_pkg::OP_SUM: begin
        rad_r  <= sqx_r + sqy_r;
        srem_r <= '0;
        root_r <= '0;
      end
      pesr_pkg::OP_SQRT: begin
        rad_r  <= {rad_r[SQW-3:0], 2'b00};
        srem_r <= sge ? (srem_sh - trial) : srem_sh;
        root_r <= {root_r[DW-2:0], sge};
      end
      pesr_pkg::OP_QSETUP: begin
        qrem_r <= root_r;
        qdv_r  <= QCW'(interval_r) << (SW - 1);
        if (root_r == '0) steps_r <= '0;
        else if (interval_r == '0 || lenx >= lim) steps_r <= SW'(pesr_pkg::MAX_STEPS);
        else steps_r <= '0;
      end
      pesr_pkg::OP_QSTEP: begin
        if (qact_r) begin
          qrem_r  <= qge ? DW'(qremx - qdv_r) : qrem_r;
          steps_r <= SW'({steps_r, qge});
          qdv_r   <= qdv_r >> 1;
        end
      end
      pesr_pkg::OP_RSETUP: begin
        nx_r    <= {absx, 1'b0};
        ny_r    <= {absy, 1'b0};
        rx_r    <= '0;
        ry_r    <= '0;
        den_r   <= {steps_r, 1'b0};
        negx_r  <= dx_r[DW-1];
        negy_r  <= dy_r[DW-1];
        accx_r  <= '0;
        accy_r  <= '0;
        raccx_r <= DEN_W'(steps_r);
        raccy_r <= DEN_W'(steps_r);
        cnt_r   <= '0;
      end
      pesr_pkg::OP_RSTEP: begin
        rx_r <= rgx ? DEN_W'(tx - denx) : DEN_W'(tx);
        ry_r <= rgy ? DEN_W'(ty - denx) : DEN_W'(ty);
        nx_r <= {nx_r[RW-2:0], rgx};
        ny_r <= {ny_r[RW-2:0], rgy};
      end
      pesr_pkg::OP_LOAD: begin
        out_r.sample_x    <= sample_of(org_x, accx_r, negx_r, center_x_r);
        out_r.sample_y    <= sample_of(org_y, accy_r, negy_r, center_y_r);
        out_r.last_of_run <= last_flag;
        cnt_r             <= cnt_r + 1'b1;
        raccx_r <= agx ? DEN_W'(rsx - denx) : DEN_W'(rsx);
        raccy_r <= agy ? DEN_W'(rsy - denx) : DEN_W'(rsy);
        accx_r  <= accx_r + nx_r + RW'(agx);
        accy_r  <= accy_r + ny_r + RW'(agy);
      end
      default: ;
    endcase
  end

  assign stat.closes     = closes_r;
  assign stat.steps_zero = (steps_r == '0);
  assign stat.more       = (cnt_r != steps_r);
  assign out_data        = out_r;

endmodule

@@ rtl/core/polyline_equal_step_resampler.sv @@
`timescale 1ns / 1ps
// a line's first sample follows its vertex request through delta, square, sum,
//   17-step root, 5-step step quotient and 18-step ratio divide; when the vertex
//   also closes, the closing step count is found first
// one sample per cycle while emitting and the consumer is ready; a segment with no
//   samples skips the ratio divide, and no new vertex request is taken until it ends
// a start vertex only moves the pen; reset restores interval 56, center 0 and pen 0
// ----------------------------------------------------------------------------
// polyline_equal_step_resampler
// Cuts each drawn line of an outline into equal steps of a configured length
// and streams the interpolated points, offset by a configured center.
// ----------------------------------------------------------------------------
module polyline_equal_step_resampler (
  input  logic                            clk,
  input  logic                            rst_n,
  pesr_vertex_if.sink                     in_vtx,
  pesr_sample_if.source                   out_smp,
  input  logic                            cfg_we,
  input  logic [pesr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pesr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between the sequencer and the datapath
  pesr_pkg::cmd_t  cmd;
  pesr_pkg::stat_t stat;

  // the sequencer takes one vertex request at a time; the sample register in
  // the datapath holds a result while the consumer stalls
  pesr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_starts (in_vtx.data.starts_subpath),
    .in_closes (in_vtx.data.closes_subpath),
    .in_ready  (in_vtx.ready),
    .out_ready (out_smp.ready),
    .out_valid (out_smp.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // length by bitwise root, step count by short restoring quotient, then
  // a per-segment divide of the doubled delta by twice the step count feeds
  // a quotient/remainder accumulator giving rounded offsets each unstalled cycle
  pesr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_vtx.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_smp.data)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyline equal-step resampler. Vertex requests
// come from a backlog queue, and each accepted vertex is run through a local
// model that lists the samples it should produce. Every sample that leaves the
// block is compared field by field with the oldest listed one. A directed
// opening covers the corner cases. Random outlines follow, under several
// interval and center settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE_CYCLES  = 150;   // a closed line runs two segments
  localparam int LONG_HOLD      = 600;   // one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [pesr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pesr_pkg::CFG_DATA_W-1:0] cfg_data;

  pesr_vertex_if vtx_if ();
  pesr_sample_if smp_if ();

  polyline_equal_step_resampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (vtx_if),
    .out_smp   (smp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // vertices waiting to be offered, samples waiting to come out
  pesr_pkg::vertex_t vertex_backlog[$];
  pesr_pkg::sample_t expected_samples[$];

  // local copy of the block: pen, subpath origin and the three registers
  logic signed [pesr_pkg::CW-1:0] pen_x, pen_y, origin_x, origin_y;
  logic [pesr_pkg::IW-1:0]        spacing;
  logic signed [pesr_pkg::CW-1:0] offset_x, offset_y;

  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  bit  long_hold_done = 1'b0;
  bit  feed_gaps      = 1'b1;
  bit  drain_stalls   = 1'b1;

  // --------------------------------------------------------------------------
  // arithmetic helpers
  // --------------------------------------------------------------------------

  // exact floor of the square root by bisection; lengths stay below 2^17
  function automatic longint floor_sqrt(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd131072;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // quotient rounded to nearest, halves away from zero
  function automatic longint round_ratio(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    return (num < 0) ? -mag : mag;
  endfunction

  // clamp into the signed q11.4 range
  function automatic logic signed [pesr_pkg::CW-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[pesr_pkg::CW-1:0];
  endfunction

  function automatic int random_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  // --------------------------------------------------------------------------
  // sample prediction
  // --------------------------------------------------------------------------

  // cut the line from the pen to (tx, ty) into equal steps, list the samples,
  // then move the pen; returns how many samples were listed
  function automatic int trace_segment(logic signed [pesr_pkg::CW-1:0] tx,
                                       logic signed [pesr_pkg::CW-1:0] ty);
    longint            dx, dy, n, s;
    pesr_pkg::sample_t smp;
    int                produced;
    produced = 0;
    dx = longint'(tx) - longint'(pen_x);
    dy = longint'(ty) - longint'(pen_y);
    if (dx != 0 || dy != 0) begin
      // a zero interval acts as an endless quotient
      if (spacing == '0) n = pesr_pkg::MAX_STEPS;
      else n = floor_sqrt(dx * dx + dy * dy) / longint'(spacing);
      if (n > pesr_pkg::MAX_STEPS) n = pesr_pkg::MAX_STEPS;
      for (s = 0; s < n; s++) begin
        smp.sample_x    = clamp_coord(longint'(pen_x) + round_ratio(dx * s, n) - offset_x);
        smp.sample_y    = clamp_coord(longint'(pen_y) + round_ratio(dy * s, n) - offset_y);
        smp.last_of_run = 1'b0;
        expected_samples.push_back(smp);
        produced++;
      end
    end
    pen_x = tx;
    pen_y = ty;
    return produced;
  endfunction

  // everything one accepted vertex request should produce
  function automatic void resample_vertex(pesr_pkg::vertex_t v);
    int                produced;
    pesr_pkg::sample_t tail;
    produced = 0;
    if (v.starts_subpath) begin
      // pen move only
      origin_x = v.vertex_x;
      origin_y = v.vertex_y;
      pen_x    = v.vertex_x;
      pen_y    = v.vertex_y;
    end else begin
      produced += trace_segment(v.vertex_x, v.vertex_y);
    end
    // closing line goes from the updated pen back to the origin
    if (v.closes_subpath) produced += trace_segment(origin_x, origin_y);
    if (produced > 0) begin
      tail = expected_samples.pop_back();
      tail.last_of_run = 1'b1;
      expected_samples.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_vertex(int x, int y, bit starts, bit closes);
    pesr_pkg::vertex_t v;
    v.vertex_x       = clamp_coord(x);
    v.vertex_y       = clamp_coord(y);
    v.starts_subpath = starts;
    v.closes_subpath = closes;
    vertex_backlog.push_back(v);
  endfunction

  // mostly well-formed subpaths: a start, a few lines with lengths spread over
  // the whole step range, sometimes a close; the rest is random noise
  task automatic queue_random_outline(int count);
    int pushed, legs, k, x, y, reach;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 6) == 0) begin
        queue_vertex(int'($urandom_range(0, 65535)) - 32768,
                     int'($urandom_range(0, 65535)) - 32768,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pushed++;
      end else begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
        queue_vertex(x, y, 1'b1, 1'b0);
        pushed++;
        legs = $urandom_range(1, 6);
        for (k = 0; k < legs; k++) begin
          reach = int'(spacing) * int'($urandom_range(0, 36))
                  + int'($urandom_range(0, int'(spacing)));
          // occasionally stay on the spot
          if ($urandom_range(0, 15) == 0) reach = 0;
          x = clamp_coord(x + int'($urandom_range(0, 2 * reach)) - reach);
          y = clamp_coord(y + int'($urandom_range(0, 2 * reach)) - reach);
          queue_vertex(x, y, 1'b0, (k == legs - 1) && ($urandom_range(0, 1) == 1));
          pushed++;
        end
      end
    end
  endtask

  // register writes on consecutive edges, only while the block is idle
  task automatic program_setting(int unsigned step, int cx, int cy);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pesr_pkg::REG_STEP_INTERVAL;
    cfg_data  <= pesr_pkg::CFG_DATA_W'(step);
    @(posedge clk);
    cfg_index <= pesr_pkg::REG_CENTER_X;
    cfg_data  <= pesr_pkg::CFG_DATA_W'(cx);
    @(posedge clk);
    cfg_index <= pesr_pkg::REG_CENTER_Y;
    cfg_data  <= pesr_pkg::CFG_DATA_W'(cy);
    @(posedge clk);
    cfg_we    <= 1'b0;
    spacing  = step[pesr_pkg::IW-1:0];
    offset_x = cx[pesr_pkg::CW-1:0];
    offset_y = cy[pesr_pkg::CW-1:0];
  endtask

  // wait for the backlog and the sample list to empty, then let a vertex that
  // produces nothing run out before anything else changes
  task automatic finish_phase();
    do @(negedge clk);
    while (vertex_backlog.size() != 0 || vtx_if.valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // vertex driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_if.valid <= 1'b0;
      vtx_if.data  <= '0;
      gap_left = 0;
    end else begin
      // request taken at this edge: predict its samples
      if (vtx_if.valid && vtx_if.ready) resample_vertex(vtx_if.data);
      if (!vtx_if.valid || vtx_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          vtx_if.valid <= 1'b0;
        end else if (vertex_backlog.size() > 0) begin
          vtx_if.data  <= vertex_backlog.pop_front();
          vtx_if.valid <= 1'b1;
          // gap after this one
          if (feed_gaps && $urandom_range(0, 3) == 0) gap_left = random_gap();
        end else begin
          vtx_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sample monitor and receiver back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pesr_pkg::sample_t want;
    if (!rst_n) begin
      smp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          $error("sample with nothing pending: sample_x %0d, sample_y %0d, last_of_run %0d",
                 smp_if.data.sample_x, smp_if.data.sample_y, smp_if.data.last_of_run);
        end else begin
          want = expected_samples.pop_front();
          if (smp_if.data.sample_x !== want.sample_x) begin
            mismatch_count++;
            $error("sample_x: expected %0d, got %0d", want.sample_x, smp_if.data.sample_x);
          end
          if (smp_if.data.sample_y !== want.sample_y) begin
            mismatch_count++;
            $error("sample_y: expected %0d, got %0d", want.sample_y, smp_if.data.sample_y);
          end
          if (smp_if.data.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            $error("last_of_run: expected %0d, got %0d",
                   want.last_of_run, smp_if.data.last_of_run);
          end
        end
      end
      // one long hold-off while the driver still has plenty queued, so the
      // block backs up and holds its input
      if (!long_hold_done && vertex_backlog.size() > 10 && expected_samples.size() > 0) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end else if (stall_left == 0 && drain_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = random_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        smp_if.ready <= 1'b0;
      end else begin
        smp_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: no request moving on either channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && !(vtx_if.valid && vtx_if.ready) && !(smp_if.valid && smp_if.ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int p;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = pesr_pkg::REG_STEP_INTERVAL;
    cfg_data     = '0;
    vtx_if.valid = 1'b0;
    vtx_if.data  = '0;
    smp_if.ready = 1'b0;
    // reset state of the block
    spacing  = pesr_pkg::STEP_INTERVAL_RST;
    offset_x = '0;
    offset_y = '0;
    pen_x    = '0;
    pen_y    = '0;
    origin_x = '0;
    origin_y = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners under the reset setting (interval 3.5 px, no center)
    @(negedge clk);
    queue_vertex(800, 0, 1'b0, 1'b0);          // line before any start, from the origin
    queue_vertex(100, 100, 1'b1, 1'b1);        // start with close: nothing
    queue_vertex(100, 100, 1'b0, 1'b0);        // zero-length line
    queue_vertex(130, 100, 1'b0, 1'b0);        // shorter than one step
    queue_vertex(-13, 101, 1'b0, 1'b0);        // two steps, halves round away from zero
    queue_vertex(32767, 32767, 1'b0, 1'b0);    // long line, step count capped
    queue_vertex(-32768, -32768, 1'b0, 1'b0);  // full diagonal the other way
    queue_vertex(-32768, 32767, 1'b1, 1'b0);
    queue_vertex(32767, -32768, 1'b0, 1'b1);   // line then close across the full range
    queue_vertex(0, 0, 1'b1, 1'b0);
    queue_vertex(1000, 0, 1'b0, 1'b0);
    queue_vertex(1000, 1000, 1'b0, 1'b0);
    queue_vertex(0, 1000, 1'b0, 1'b1);         // closed square
    queue_vertex(-170, -5, 1'b0, 1'b0);        // negative deltas, thirds
    queue_vertex(-170, -5, 1'b0, 1'b1);        // zero-length line, then close
    finish_phase();

    // finest interval with extreme centers: outputs pinned at the range ends
    feed_gaps    = 1'b0;
    drain_stalls = 1'b0;
    program_setting(1, 32767, -32768);
    @(negedge clk);
    queue_vertex(-32768, 32767, 1'b1, 1'b0);
    queue_vertex(-32700, 32767, 1'b0, 1'b0);
    queue_vertex(32767, -32768, 1'b0, 1'b1);
    queue_vertex(5, 5, 1'b1, 1'b0);
    queue_vertex(6, 5, 1'b0, 1'b0);            // a single step
    finish_phase();

    // random outlines under a spread of settings
    for (p = 0; p < 6; p++) begin
      feed_gaps    = (p % 3 != 2);
      drain_stalls = (p % 3 != 1);
      case (p)
        0: program_setting(4095, 0, 0);
        1: program_setting(1, -32768, 32767);
        2: program_setting(56, int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768);
        3: program_setting($urandom_range(1, 4095), int'($urandom_range(0, 65535)) - 32768,
                           int'($urandom_range(0, 65535)) - 32768);
        default: program_setting($urandom_range(1, 400),
                                 int'($urandom_range(0, 4095)) - 2048,
                                 int'($urandom_range(0, 4095)) - 2048);
      endcase
      @(negedge clk);
      queue_random_outline(33);
      finish_phase();
    end

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
